@@ rtl/stok_pkg.sv @@
// stok_pkg: shared types, constants and helper functions of the source tokenizer
// used by stok_scan, stok_queue, source_tokenizer and stok_checker
// no dependencies
package stok_pkg;

    // sizes
    localparam int SOURCE_CAPACITY = 1024;
    localparam int MAX_TOKEN_CHARS = 255;
    localparam int POS_W           = $clog2(SOURCE_CAPACITY) + 1;
    localparam int BYTE_W          = 8;
    localparam int KIND_W          = 5;
    localparam int KWN_W           = 4;
    localparam int START_W         = 10;
    localparam int LEN_W           = 8;
    localparam int STATUS_W        = 3;
    localparam int PREFIX_BYTES    = 5;
    localparam int PREFIX_W        = PREFIX_BYTES * BYTE_W;
    localparam int KW_COUNT        = 9;
    localparam int QUEUE_DEPTH     = 4;
    localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);

    // token kinds
    localparam logic [KIND_W-1:0] KIND_CONST   = 5'd0;
    localparam logic [KIND_W-1:0] KIND_IDENT   = 5'd1;
    localparam logic [KIND_W-1:0] KIND_KEYWORD = 5'd2;
    localparam logic [KIND_W-1:0] KIND_ADD     = 5'd3;
    localparam logic [KIND_W-1:0] KIND_SUB     = 5'd4;
    localparam logic [KIND_W-1:0] KIND_MUL     = 5'd5;
    localparam logic [KIND_W-1:0] KIND_DIV     = 5'd6;
    localparam logic [KIND_W-1:0] KIND_ASSIGN  = 5'd7;
    localparam logic [KIND_W-1:0] KIND_SEMI    = 5'd8;
    localparam logic [KIND_W-1:0] KIND_OPEN    = 5'd9;
    localparam logic [KIND_W-1:0] KIND_CLOSE   = 5'd10;
    localparam logic [KIND_W-1:0] KIND_GT      = 5'd11;
    localparam logic [KIND_W-1:0] KIND_LT      = 5'd12;
    localparam logic [KIND_W-1:0] KIND_GTE     = 5'd13;
    localparam logic [KIND_W-1:0] KIND_LTE     = 5'd14;
    localparam logic [KIND_W-1:0] KIND_EQ      = 5'd15;
    localparam logic [KIND_W-1:0] KIND_AND     = 5'd16;
    localparam logic [KIND_W-1:0] KIND_OR      = 5'd17;

    // token status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_MALFORMED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_UNKNOWN   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_TOO_LONG  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_CAPACITY  = 3'd4;

    // character codes
    localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [BYTE_W-1:0] CH_TAB    = 8'h09;
    localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_PLUS   = 8'h2B;
    localparam logic [BYTE_W-1:0] CH_MINUS  = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_STAR   = 8'h2A;
    localparam logic [BYTE_W-1:0] CH_SLASH  = 8'h2F;
    localparam logic [BYTE_W-1:0] CH_SEMI   = 8'h3B;
    localparam logic [BYTE_W-1:0] CH_LPAREN = 8'h28;
    localparam logic [BYTE_W-1:0] CH_RPAREN = 8'h29;
    localparam logic [BYTE_W-1:0] CH_EQUAL  = 8'h3D;
    localparam logic [BYTE_W-1:0] CH_LESS   = 8'h3C;
    localparam logic [BYTE_W-1:0] CH_MORE   = 8'h3E;
    localparam logic [BYTE_W-1:0] CH_AMP    = 8'h26;
    localparam logic [BYTE_W-1:0] CH_BAR    = 8'h7C;
    localparam logic [BYTE_W-1:0] CH_LETTER_LO = 8'd65;
    localparam logic [BYTE_W-1:0] CH_LETTER_HI = 8'd122;
    localparam logic [BYTE_W-1:0] CH_DIGIT_LO  = 8'd48;
    localparam logic [BYTE_W-1:0] CH_DIGIT_HI  = 8'd57;

    // keyword text, first character in the low byte
    localparam logic [PREFIX_W-1:0] KW_TEXT [KW_COUNT] = '{
        40'h0000666564,  // def
        40'h006e69616d,  // main
        40'h0000006f64,  // do
        40'h0000646e65,  // end
        40'h0000006669,  // if
        40'h0065736c65,  // else
        40'h656c696877,  // while
        40'h0073747570,  // puts
        40'h7364616572   // reads
    };
    localparam logic [LEN_W-1:0] KW_LEN [KW_COUNT] = '{
        8'd3, 8'd4, 8'd2, 8'd3, 8'd2, 8'd4, 8'd5, 8'd4, 8'd5
    };

    // one-hot scanner modes
    typedef enum logic [8:0] {
        MODE_IDLE   = 9'b000000001,
        MODE_WORD   = 9'b000000010,
        MODE_NUMBER = 9'b000000100,
        MODE_EQ     = 9'b000001000,
        MODE_LT     = 9'b000010000,
        MODE_GT     = 9'b000100000,
        MODE_AMP    = 9'b001000000,
        MODE_BAR    = 9'b010000000,
        MODE_HALT   = 9'b100000000
    } t_mode;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [KWN_W-1:0]    kw_num;
        logic [START_W-1:0]  start;
        logic [LEN_W-1:0]    len;
        logic [STATUS_W-1:0] status;
        logic                run_end;
    } t_token;

    typedef struct packed {
        logic   vld;
        t_token tok;
    } t_slot;

    function automatic logic is_letter(input logic [BYTE_W-1:0] b);
        return (b >= CH_LETTER_LO) && (b <= CH_LETTER_HI);
    endfunction

    function automatic logic is_digit(input logic [BYTE_W-1:0] b);
        return (b >= CH_DIGIT_LO) && (b <= CH_DIGIT_HI);
    endfunction

    function automatic t_slot make_slot(input logic [KIND_W-1:0] kind,
                                        input logic [START_W-1:0] start,
                                        input logic [LEN_W-1:0] len,
                                        input logic [STATUS_W-1:0] status);
        t_slot s;
        s.vld         = 1'b1;
        s.tok.kind    = kind;
        s.tok.kw_num  = '0;
        s.tok.start   = start;
        s.tok.len     = len;
        s.tok.status  = status;
        s.tok.run_end = 1'b0;
        return s;
    endfunction

    // token left behind by a pending run when it ends
    function automatic t_slot flush_slot(input t_mode mode,
                                         input logic [PREFIX_W-1:0] prefix,
                                         input logic [LEN_W-1:0] len,
                                         input logic [START_W-1:0] start,
                                         input logic overlong);
        t_slot               s;
        logic                hit;
        logic [KWN_W-1:0]    kwn;
        logic [STATUS_W-1:0] st;
        hit = 1'b0;
        kwn = '0;
        s   = '0;
        for (int i = 0; i < KW_COUNT; i++) begin
            if (!hit && !overlong && len == KW_LEN[i] && prefix == KW_TEXT[i]) begin
                hit = 1'b1;
                kwn = KWN_W'(i);
            end
        end
        st = overlong ? ST_TOO_LONG : ST_OK;
        unique case (mode)
            MODE_WORD: begin
                if (hit) begin
                    s = make_slot(KIND_KEYWORD, start, len, ST_OK);
                    s.tok.kw_num = kwn;
                end else begin
                    s = make_slot(KIND_IDENT, start, len, st);
                end
            end
            MODE_NUMBER: s = make_slot(KIND_CONST, start, len, st);
            MODE_EQ:     s = make_slot(KIND_ASSIGN, start, LEN_W'(1), ST_OK);
            MODE_LT:     s = make_slot(KIND_LT, start, LEN_W'(1), ST_OK);
            MODE_GT:     s = make_slot(KIND_GT, start, LEN_W'(1), ST_OK);
            MODE_AMP, MODE_BAR: s = make_slot(KIND_OR, start, LEN_W'(1), ST_MALFORMED);
            default:     s = '0;
        endcase
        return s;
    endfunction

endpackage

@@ rtl/stok_scan.sv @@
// stok_scan: front end, takes one source byte per transaction and classifies it
// produces up to two tokens per byte for the queue
// depends on stok_pkg
module stok_scan (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_take,
    input  logic [stok_pkg::BYTE_W-1:0]  i_source_byte,
    input  logic                         i_final_byte,
    output stok_pkg::t_slot              o_slot0,
    output stok_pkg::t_slot              o_slot1
);

    stok_pkg::t_mode                      r_mode, n_mode;
    logic [stok_pkg::PREFIX_W-1:0]        r_prefix, n_prefix;
    logic [stok_pkg::LEN_W-1:0]           r_len, n_len;
    logic [stok_pkg::START_W-1:0]         r_start, n_start;
    logic [stok_pkg::POS_W-1:0]           r_pos, n_pos;
    logic                                 r_over, n_over;

    stok_pkg::t_slot                      f_cur;
    stok_pkg::t_slot                      a_slot, b_slot, c_slot;
    stok_pkg::t_slot                      s0, s1;
    logic                                 rescan, extend;
    logic [stok_pkg::START_W-1:0]         pos_s;
    logic                                 same_gate;

    assign pos_s = r_pos[stok_pkg::START_W-1:0];

    // token of the run pending before this byte
    assign f_cur = stok_pkg::flush_slot(r_mode, r_prefix, r_len, r_start, r_over);

    // next state and tokens for the byte
    always_comb begin
        n_mode    = r_mode;
        n_prefix  = r_prefix;
        n_len     = r_len;
        n_start   = r_start;
        n_pos     = r_pos;
        n_over    = r_over;
        a_slot    = '0;
        b_slot    = '0;
        c_slot    = '0;
        rescan    = 1'b0;
        extend    = 1'b0;
        same_gate = ((r_mode == stok_pkg::MODE_AMP) == (i_source_byte == stok_pkg::CH_AMP));

        if (r_mode != stok_pkg::MODE_HALT) begin
            if (r_pos >= stok_pkg::POS_W'(stok_pkg::SOURCE_CAPACITY)) begin
                // source past capacity: flush then halt
                a_slot = f_cur;
                b_slot = stok_pkg::make_slot(stok_pkg::KIND_CONST, pos_s, '0,
                                             stok_pkg::ST_CAPACITY);
                n_mode = stok_pkg::MODE_HALT;
            end else begin
                unique case (r_mode)
                    stok_pkg::MODE_WORD: begin
                        if (stok_pkg::is_letter(i_source_byte) ||
                            stok_pkg::is_digit(i_source_byte)) begin
                            extend = 1'b1;
                        end else begin
                            a_slot = f_cur;
                            rescan = 1'b1;
                        end
                    end
                    stok_pkg::MODE_NUMBER: begin
                        if (stok_pkg::is_digit(i_source_byte)) begin
                            extend = 1'b1;
                        end else begin
                            a_slot = f_cur;
                            rescan = 1'b1;
                        end
                    end
                    stok_pkg::MODE_EQ, stok_pkg::MODE_LT, stok_pkg::MODE_GT: begin
                        if (i_source_byte == stok_pkg::CH_EQUAL) begin
                            a_slot = stok_pkg::make_slot(
                                (r_mode == stok_pkg::MODE_EQ) ? stok_pkg::KIND_EQ :
                                (r_mode == stok_pkg::MODE_LT) ? stok_pkg::KIND_LTE :
                                                                stok_pkg::KIND_GTE,
                                r_start, stok_pkg::LEN_W'(2), stok_pkg::ST_OK);
                            n_mode = stok_pkg::MODE_IDLE;
                        end else begin
                            a_slot = f_cur;
                            rescan = 1'b1;
                        end
                    end
                    stok_pkg::MODE_AMP, stok_pkg::MODE_BAR: begin
                        if (i_source_byte == stok_pkg::CH_AMP ||
                            i_source_byte == stok_pkg::CH_BAR) begin
                            a_slot = stok_pkg::make_slot(
                                (same_gate && i_source_byte == stok_pkg::CH_AMP) ?
                                    stok_pkg::KIND_AND : stok_pkg::KIND_OR,
                                r_start, stok_pkg::LEN_W'(2),
                                same_gate ? stok_pkg::ST_OK : stok_pkg::ST_MALFORMED);
                            n_mode = stok_pkg::MODE_IDLE;
                        end else begin
                            a_slot = f_cur;
                            rescan = 1'b1;
                        end
                    end
                    default: rescan = 1'b1;
                endcase

                // grow the current word or number
                if (extend) begin
                    for (int j = 0; j < stok_pkg::PREFIX_BYTES; j++) begin
                        if (r_len == stok_pkg::LEN_W'(j)) begin
                            n_prefix[stok_pkg::BYTE_W*j +: stok_pkg::BYTE_W] = i_source_byte;
                        end
                    end
                    if (r_len < stok_pkg::LEN_W'(stok_pkg::MAX_TOKEN_CHARS)) begin
                        n_len = r_len + stok_pkg::LEN_W'(1);
                    end else begin
                        n_over = 1'b1;
                    end
                end

                // classify the byte from idle
                if (rescan) begin
                    n_mode = stok_pkg::MODE_IDLE;
                    priority if (i_source_byte == stok_pkg::CH_SPACE ||
                                 i_source_byte == stok_pkg::CH_TAB ||
                                 i_source_byte == stok_pkg::CH_LF) begin
                        n_mode = stok_pkg::MODE_IDLE;
                    end else if (stok_pkg::is_letter(i_source_byte) ||
                                 stok_pkg::is_digit(i_source_byte)) begin
                        n_mode   = stok_pkg::is_letter(i_source_byte) ?
                                   stok_pkg::MODE_WORD : stok_pkg::MODE_NUMBER;
                        n_start  = pos_s;
                        n_len    = stok_pkg::LEN_W'(1);
                        n_over   = 1'b0;
                        n_prefix = stok_pkg::PREFIX_W'(i_source_byte);
                    end else begin
                        unique case (i_source_byte)
                            stok_pkg::CH_PLUS:   b_slot = stok_pkg::make_slot(
                                stok_pkg::KIND_ADD, pos_s, stok_pkg::LEN_W'(1), stok_pkg::ST_OK);
                            stok_pkg::CH_MINUS:  b_slot = stok_pkg::make_slot(
                                stok_pkg::KIND_SUB, pos_s, stok_pkg::LEN_W'(1), stok_pkg::ST_OK);
                            stok_pkg::CH_STAR:   b_slot = stok_pkg::make_slot(
                                stok_pkg::KIND_MUL, pos_s, stok_pkg::LEN_W'(1), stok_pkg::ST_OK);
                            stok_pkg::CH_SLASH:  b_slot = stok_pkg::make_slot(
                                stok_pkg::KIND_DIV, pos_s, stok_pkg::LEN_W'(1), stok_pkg::ST_OK);
                            stok_pkg::CH_SEMI:   b_slot = stok_pkg::make_slot(
                                stok_pkg::KIND_SEMI, pos_s, stok_pkg::LEN_W'(1), stok_pkg::ST_OK);
                            stok_pkg::CH_LPAREN: b_slot = stok_pkg::make_slot(
                                stok_pkg::KIND_OPEN, pos_s, stok_pkg::LEN_W'(1), stok_pkg::ST_OK);
                            stok_pkg::CH_RPAREN: b_slot = stok_pkg::make_slot(
                                stok_pkg::KIND_CLOSE, pos_s, stok_pkg::LEN_W'(1), stok_pkg::ST_OK);
                            stok_pkg::CH_EQUAL, stok_pkg::CH_LESS, stok_pkg::CH_MORE,
                            stok_pkg::CH_AMP, stok_pkg::CH_BAR: begin
                                n_mode   = (i_source_byte == stok_pkg::CH_EQUAL) ?
                                               stok_pkg::MODE_EQ :
                                           (i_source_byte == stok_pkg::CH_LESS) ?
                                               stok_pkg::MODE_LT :
                                           (i_source_byte == stok_pkg::CH_MORE) ?
                                               stok_pkg::MODE_GT :
                                           (i_source_byte == stok_pkg::CH_AMP) ?
                                               stok_pkg::MODE_AMP : stok_pkg::MODE_BAR;
                                n_start  = pos_s;
                                n_len    = stok_pkg::LEN_W'(1);
                                n_over   = 1'b0;
                                n_prefix = stok_pkg::PREFIX_W'(i_source_byte);
                            end
                            default: begin
                                // unknown symbol halts the scanner
                                b_slot = stok_pkg::make_slot(stok_pkg::KIND_CONST, pos_s,
                                                             stok_pkg::LEN_W'(1),
                                                             stok_pkg::ST_UNKNOWN);
                                n_mode = stok_pkg::MODE_HALT;
                            end
                        endcase
                    end
                end

                n_pos = r_pos + stok_pkg::POS_W'(1);

                // final byte flushes and restarts at offset zero
                if (i_final_byte && n_mode != stok_pkg::MODE_HALT) begin
                    c_slot = stok_pkg::flush_slot(n_mode, n_prefix, n_len, n_start, n_over);
                    n_pos  = '0;
                    n_mode = stok_pkg::MODE_IDLE;
                end
            end
        end
    end

    // pack the tokens into the two slots in order and mark the last one
    always_comb begin
        s0 = a_slot.vld ? a_slot : (b_slot.vld ? b_slot : c_slot);
        s1 = a_slot.vld ? (b_slot.vld ? b_slot : c_slot) : (b_slot.vld ? c_slot : '0);
        if (s1.vld) begin
            s1.tok.run_end = 1'b1;
        end else begin
            s0.tok.run_end = s0.vld;
        end
        s0.vld = s0.vld & i_take;
        s1.vld = s1.vld & i_take;
    end

    assign o_slot0 = s0;
    assign o_slot1 = s1;

    // scanner state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= stok_pkg::MODE_IDLE;
            r_prefix <= '0;
            r_len    <= '0;
            r_start  <= '0;
            r_pos    <= '0;
            r_over   <= 1'b0;
        end else if (i_take) begin
            r_mode   <= n_mode;
            r_prefix <= n_prefix;
            r_len    <= n_len;
            r_start  <= n_start;
            r_pos    <= n_pos;
            r_over   <= n_over;
        end
    end

endmodule

@@ rtl/stok_queue.sv @@
// stok_queue: short token queue between the scanner and the output port
// takes up to two tokens per cycle and hands out one per cycle when popped
// depends on stok_pkg
module stok_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  stok_pkg::t_slot  i_slot0,
    input  stok_pkg::t_slot  i_slot1,
    input  logic             i_pop,
    output logic             o_valid,
    output stok_pkg::t_token o_token,
    output logic             o_no_room
);

    stok_pkg::t_token                r_mem [stok_pkg::QUEUE_DEPTH];
    logic [stok_pkg::QPTR_W-1:0]     r_wp, n_wp;
    logic [stok_pkg::QPTR_W-1:0]     r_rp, n_rp;
    logic [stok_pkg::QCNT_W-1:0]     r_cnt, n_cnt;
    logic                            pop;
    logic [stok_pkg::QPTR_W-1:0]     wp1;

    assign pop       = i_pop && (r_cnt != '0);
    assign wp1       = r_wp + stok_pkg::QPTR_W'(1);
    assign o_valid   = (r_cnt != '0);
    assign o_token   = r_mem[r_rp];
    assign o_no_room = (r_cnt > stok_pkg::QCNT_W'(stok_pkg::QUEUE_DEPTH - 2));

    // pointer and fill bookkeeping
    always_comb begin
        n_wp  = r_wp + stok_pkg::QPTR_W'(i_slot0.vld) + stok_pkg::QPTR_W'(i_slot1.vld);
        n_rp  = r_rp + stok_pkg::QPTR_W'(pop);
        n_cnt = r_cnt + stok_pkg::QCNT_W'(i_slot0.vld) + stok_pkg::QCNT_W'(i_slot1.vld)
                - stok_pkg::QCNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // token storage
    always_ff @(posedge i_clk) begin
        if (i_slot0.vld) begin
            r_mem[r_wp] <= i_slot0.tok;
        end
        if (i_slot1.vld) begin
            r_mem[wp1] <= i_slot1.tok;
        end
    end

endmodule

@@ rtl/source_tokenizer.sv @@
// source_tokenizer: top level of the byte-stream tokenizer
// joins the scanner front end and the token queue; depends on stok_pkg,
// stok_scan and stok_queue
//
// One source byte is taken per clock while the token queue has room for two
// more tokens; a token enters the token queue when the byte that completes it
// is taken and is shown once it is at the head of the queue. The output port
// hands out one token per cycle unless stalled, so a stream in which every
// byte yields two tokens (for instance a run closed by a one-byte operator)
// is held back by that single output port and the four-entry queue. There is
// no clearing pass after reset. After an unknown symbol or a source past
// capacity the block keeps taking bytes but yields no tokens until reset.
module source_tokenizer (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [7:0]                     i_source_byte,
    input  logic                           i_final_byte,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [stok_pkg::KIND_W-1:0]    o_token_kind,
    output logic [stok_pkg::KWN_W-1:0]     o_keyword_number,
    output logic [stok_pkg::START_W-1:0]   o_token_start,
    output logic [stok_pkg::LEN_W-1:0]     o_token_length,
    output logic [stok_pkg::STATUS_W-1:0]  o_token_status,
    output logic                           o_run_end
);

    logic             take;
    logic             no_room;
    stok_pkg::t_slot  slot0, slot1;
    stok_pkg::t_token head;

    // input transaction
    assign o_stall = no_room;
    assign take    = i_valid && !no_room;

    stok_scan u_scan (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_take        (take),
        .i_source_byte (i_source_byte),
        .i_final_byte  (i_final_byte),
        .o_slot0       (slot0),
        .o_slot1       (slot1)
    );

    stok_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_slot0   (slot0),
        .i_slot1   (slot1),
        .i_pop     (!i_stall),
        .o_valid   (o_valid),
        .o_token   (head),
        .o_no_room (no_room)
    );

    // output fields
    assign o_token_kind     = head.kind;
    assign o_keyword_number = head.kw_num;
    assign o_token_start    = head.start;
    assign o_token_length   = head.len;
    assign o_token_status   = head.status;
    assign o_run_end        = head.run_end;

endmodule

@@ rtl/stok_checker.sv @@
// stok_checker: port-level checks on the source tokenizer, bound to the top
// depends on stok_pkg and source_tokenizer
module stok_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  logic                           o_stall,
    input  logic [7:0]                     i_source_byte,
    input  logic                           i_final_byte,
    input  logic                           o_valid,
    input  logic                           i_stall,
    input  logic [stok_pkg::KIND_W-1:0]    o_token_kind,
    input  logic [stok_pkg::KWN_W-1:0]     o_keyword_number,
    input  logic [stok_pkg::START_W-1:0]   o_token_start,
    input  logic [stok_pkg::LEN_W-1:0]     o_token_length,
    input  logic [stok_pkg::STATUS_W-1:0]  o_token_status,
    input  logic                           o_run_end
);

    // a stalled input transaction keeps its byte
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_stall |=> i_valid && $stable(i_source_byte) && $stable(i_final_byte))
        else $error("stalled source byte changed");

    // a stalled output transaction holds its token
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_token_kind) &&
        $stable(o_keyword_number) && $stable(o_token_start) &&
        $stable(o_token_length) && $stable(o_token_status) && $stable(o_run_end))
        else $error("stalled token changed");

    // halting tokens are always the last of their byte
    a_halt_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_token_status == stok_pkg::ST_UNKNOWN ||
                    o_token_status == stok_pkg::ST_CAPACITY) |->
        o_run_end && o_token_kind == stok_pkg::KIND_CONST)
        else $error("halting token malformed");

    // keyword number only on keywords
    a_kw_num: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_token_kind != stok_pkg::KIND_KEYWORD |-> o_keyword_number == '0)
        else $error("keyword number on a non-keyword");

    // nothing follows a halting token once it has been taken
    a_halt_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && (o_token_status == stok_pkg::ST_UNKNOWN ||
                                o_token_status == stok_pkg::ST_CAPACITY) |=> !o_valid)
        else $error("token after halt");

endmodule

bind source_tokenizer stok_checker u_stok_checker (.*);

@@ dv/tb.sv @@
// tb: self-checking bench for source_tokenizer, one byte per input transaction
// predicts the tokens of every accepted byte and checks each output transaction
// depends on stok_pkg and the source_tokenizer rtl
module tb;

    localparam int CYCLE_LIMIT   = 600000;
    localparam int RANDOM_BYTES  = 150;
    localparam int LONG_HOLD     = 160;
    localparam int SETTLE_CYCLES = 16;
    localparam int LONG_RUNS     = 2;

    // predicted token stream and the check of what comes out
    class t_token_scoreboard;
        string                          kw_text [stok_pkg::KW_COUNT];
        stok_pkg::t_mode                mode;
        logic [stok_pkg::PREFIX_W-1:0]  prefix;
        int unsigned                    run_len;
        logic [stok_pkg::START_W-1:0]   run_start;
        int unsigned                    position;
        bit                             overlong;
        stok_pkg::t_token               expected_tokens [$];
        int                             errors;

        function new();
            kw_text   = '{"def", "main", "do", "end", "if", "else", "while", "puts",
                          "reads"};
            mode      = stok_pkg::MODE_IDLE;
            prefix    = '0;
            run_len   = 0;
            run_start = '0;
            position  = 0;
            overlong  = 1'b0;
            errors    = 0;
        endfunction

        function bit letter_byte(logic [7:0] b);
            return b >= stok_pkg::CH_LETTER_LO && b <= stok_pkg::CH_LETTER_HI;
        endfunction

        function bit digit_byte(logic [7:0] b);
            return b >= stok_pkg::CH_DIGIT_LO && b <= stok_pkg::CH_DIGIT_HI;
        endfunction

        function void push_token(logic [stok_pkg::KIND_W-1:0] kind,
                                 logic [stok_pkg::KWN_W-1:0] kwn,
                                 int unsigned start, int unsigned len,
                                 logic [stok_pkg::STATUS_W-1:0] status);
            stok_pkg::t_token t;
            t.kind    = kind;
            t.kw_num  = kwn;
            t.start   = stok_pkg::START_W'(start);
            t.len     = stok_pkg::LEN_W'(len);
            t.status  = status;
            t.run_end = 1'b0;
            expected_tokens.push_back(t);
        endfunction

        function void open_run(logic [7:0] b, int unsigned pos, stok_pkg::t_mode m);
            mode        = m;
            run_start   = stok_pkg::START_W'(pos);
            run_len     = 1;
            overlong    = 1'b0;
            prefix      = '0;
            prefix[7:0] = b;
        endfunction

        function void grow_run(logic [7:0] b);
            if (run_len < stok_pkg::PREFIX_BYTES) prefix[8*run_len +: 8] = b;
            if (run_len < stok_pkg::MAX_TOKEN_CHARS) run_len++;
            else overlong = 1'b1;
        endfunction

        // token left by a pending run
        function void close_run();
            int                            kw;
            int                            i;
            int                            j;
            bit                            hit;
            logic [stok_pkg::STATUS_W-1:0] st;
            kw = -1;
            st = overlong ? stok_pkg::ST_TOO_LONG : stok_pkg::ST_OK;
            case (mode)
                stok_pkg::MODE_WORD: begin
                    if (!overlong && run_len <= stok_pkg::PREFIX_BYTES) begin
                        for (i = 0; i < stok_pkg::KW_COUNT; i++) begin
                            hit = (kw_text[i].len() == run_len);
                            for (j = 0; hit && j < kw_text[i].len(); j++)
                                hit = (prefix[8*j +: 8] == kw_text[i][j]);
                            if (hit && kw < 0) kw = i;
                        end
                    end
                    if (kw >= 0)
                        push_token(stok_pkg::KIND_KEYWORD, stok_pkg::KWN_W'(kw),
                                   run_start, run_len, stok_pkg::ST_OK);
                    else
                        push_token(stok_pkg::KIND_IDENT, '0, run_start, run_len, st);
                end
                stok_pkg::MODE_NUMBER:
                    push_token(stok_pkg::KIND_CONST, '0, run_start, run_len, st);
                stok_pkg::MODE_EQ:
                    push_token(stok_pkg::KIND_ASSIGN, '0, run_start, 1, stok_pkg::ST_OK);
                stok_pkg::MODE_LT:
                    push_token(stok_pkg::KIND_LT, '0, run_start, 1, stok_pkg::ST_OK);
                stok_pkg::MODE_GT:
                    push_token(stok_pkg::KIND_GT, '0, run_start, 1, stok_pkg::ST_OK);
                stok_pkg::MODE_AMP, stok_pkg::MODE_BAR:
                    push_token(stok_pkg::KIND_OR, '0, run_start, 1, stok_pkg::ST_MALFORMED);
                default: ;
            endcase
            if (mode != stok_pkg::MODE_HALT) mode = stok_pkg::MODE_IDLE;
        endfunction

        // advance the scanner by one accepted byte
        function void scan_byte(logic [7:0] b, logic last);
            int unsigned      pos;
            int               prior_count;
            bit               rescan;
            bit               same;
            stok_pkg::t_token t;
            if (mode == stok_pkg::MODE_HALT) return;
            pos         = position;
            prior_count = expected_tokens.size();
            rescan      = 1'b0;
            if (pos >= stok_pkg::SOURCE_CAPACITY) begin
                close_run();
                push_token(stok_pkg::KIND_CONST, '0, pos, 0, stok_pkg::ST_CAPACITY);
                mode = stok_pkg::MODE_HALT;
            end else begin
                case (mode)
                    stok_pkg::MODE_WORD: begin
                        if (letter_byte(b) || digit_byte(b)) grow_run(b);
                        else begin
                            close_run();
                            rescan = 1'b1;
                        end
                    end
                    stok_pkg::MODE_NUMBER: begin
                        if (digit_byte(b)) grow_run(b);
                        else begin
                            close_run();
                            rescan = 1'b1;
                        end
                    end
                    stok_pkg::MODE_EQ, stok_pkg::MODE_LT, stok_pkg::MODE_GT: begin
                        if (b == stok_pkg::CH_EQUAL) begin
                            push_token(mode == stok_pkg::MODE_EQ ? stok_pkg::KIND_EQ :
                                       (mode == stok_pkg::MODE_LT ? stok_pkg::KIND_LTE :
                                                                    stok_pkg::KIND_GTE),
                                       '0, run_start, 2, stok_pkg::ST_OK);
                            mode = stok_pkg::MODE_IDLE;
                        end else begin
                            close_run();
                            rescan = 1'b1;
                        end
                    end
                    stok_pkg::MODE_AMP, stok_pkg::MODE_BAR: begin
                        if (b == stok_pkg::CH_AMP || b == stok_pkg::CH_BAR) begin
                            same = ((mode == stok_pkg::MODE_AMP) == (b == stok_pkg::CH_AMP));
                            push_token((same && b == stok_pkg::CH_AMP) ?
                                           stok_pkg::KIND_AND : stok_pkg::KIND_OR, '0,
                                       run_start, 2,
                                       same ? stok_pkg::ST_OK : stok_pkg::ST_MALFORMED);
                            mode = stok_pkg::MODE_IDLE;
                        end else begin
                            close_run();
                            rescan = 1'b1;
                        end
                    end
                    default: rescan = 1'b1;
                endcase
                // byte seen from the idle state
                if (rescan) begin
                    mode = stok_pkg::MODE_IDLE;
                    if (letter_byte(b)) open_run(b, pos, stok_pkg::MODE_WORD);
                    else if (digit_byte(b)) open_run(b, pos, stok_pkg::MODE_NUMBER);
                    else if (b != stok_pkg::CH_SPACE && b != stok_pkg::CH_TAB &&
                             b != stok_pkg::CH_LF) begin
                        case (b)
                            stok_pkg::CH_PLUS:
                                push_token(stok_pkg::KIND_ADD, '0, pos, 1, stok_pkg::ST_OK);
                            stok_pkg::CH_MINUS:
                                push_token(stok_pkg::KIND_SUB, '0, pos, 1, stok_pkg::ST_OK);
                            stok_pkg::CH_STAR:
                                push_token(stok_pkg::KIND_MUL, '0, pos, 1, stok_pkg::ST_OK);
                            stok_pkg::CH_SLASH:
                                push_token(stok_pkg::KIND_DIV, '0, pos, 1, stok_pkg::ST_OK);
                            stok_pkg::CH_SEMI:
                                push_token(stok_pkg::KIND_SEMI, '0, pos, 1, stok_pkg::ST_OK);
                            stok_pkg::CH_LPAREN:
                                push_token(stok_pkg::KIND_OPEN, '0, pos, 1, stok_pkg::ST_OK);
                            stok_pkg::CH_RPAREN:
                                push_token(stok_pkg::KIND_CLOSE, '0, pos, 1, stok_pkg::ST_OK);
                            stok_pkg::CH_EQUAL: open_run(b, pos, stok_pkg::MODE_EQ);
                            stok_pkg::CH_LESS:  open_run(b, pos, stok_pkg::MODE_LT);
                            stok_pkg::CH_MORE:  open_run(b, pos, stok_pkg::MODE_GT);
                            stok_pkg::CH_AMP:   open_run(b, pos, stok_pkg::MODE_AMP);
                            stok_pkg::CH_BAR:   open_run(b, pos, stok_pkg::MODE_BAR);
                            default: begin
                                push_token(stok_pkg::KIND_CONST, '0, pos, 1,
                                           stok_pkg::ST_UNKNOWN);
                                mode = stok_pkg::MODE_HALT;
                            end
                        endcase
                    end
                end
                position = pos + 1;
                if (last && mode != stok_pkg::MODE_HALT) begin
                    close_run();
                    position = 0;
                    mode     = stok_pkg::MODE_IDLE;
                end
            end
            // flag the last token of this byte
            if (expected_tokens.size() > prior_count) begin
                t = expected_tokens.pop_back();
                t.run_end = 1'b1;
                expected_tokens.push_back(t);
            end
        endfunction

        function void check_token(stok_pkg::t_token got);
            stok_pkg::t_token want;
            if (expected_tokens.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected token: kind %0d kw %0d start %0d len %0d %s",
                             got.kind, got.kw_num, got.start, got.len,
                             $sformatf("status %0d end %0b", got.status, got.run_end));
                return;
            end
            want = expected_tokens.pop_front();
            if (got.kind !== want.kind || got.kw_num !== want.kw_num ||
                got.start !== want.start || got.len !== want.len ||
                got.status !== want.status || got.run_end !== want.run_end) begin
                errors++;
                if (errors <= 10) begin
                    $display("token mismatch: expected kind %0d kw %0d start %0d %s",
                             want.kind, want.kw_num, want.start,
                             $sformatf("len %0d status %0d end %0b",
                                       want.len, want.status, want.run_end));
                    $display("                got      kind %0d kw %0d start %0d %s",
                             got.kind, got.kw_num, got.start,
                             $sformatf("len %0d status %0d end %0b",
                                       got.len, got.status, got.run_end));
                end
            end
        endfunction
    endclass

    logic                          i_clk         = 1'b0;
    logic                          i_rst_n       = 1'b0;
    logic                          i_valid       = 1'b0;
    logic                          o_stall;
    logic [7:0]                    i_source_byte = '0;
    logic                          i_final_byte  = 1'b0;
    logic                          o_valid;
    logic                          i_stall       = 1'b0;
    logic [stok_pkg::KIND_W-1:0]   o_token_kind;
    logic [stok_pkg::KWN_W-1:0]    o_keyword_number;
    logic [stok_pkg::START_W-1:0]  o_token_start;
    logic [stok_pkg::LEN_W-1:0]    o_token_length;
    logic [stok_pkg::STATUS_W-1:0] o_token_status;
    logic                          o_run_end;

    t_token_scoreboard sb;
    logic [7:0]        text_q [$];
    int unsigned       src_pos      = 0;
    int unsigned       cycles       = 0;
    bit                calm         = 1'b0;
    bit                hold_request = 1'b0;

    source_tokenizer dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_source_byte    (i_source_byte),
        .i_final_byte     (i_final_byte),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_token_kind     (o_token_kind),
        .o_keyword_number (o_keyword_number),
        .o_token_start    (o_token_start),
        .o_token_length   (o_token_length),
        .o_token_status   (o_token_status),
        .o_run_end        (o_run_end)
    );

    initial begin : clock_gen
        forever #2 i_clk = ~i_clk;
    end

    // idle cycles before the next transaction on either side
    function automatic int idle_draw();
        return calm ? 0 : int'($urandom_range(0, 7));
    endfunction

    function automatic logic [7:0] word_char();
        if ($urandom_range(0, 3) == 0)
            return 8'($urandom_range(stok_pkg::CH_DIGIT_LO, stok_pkg::CH_DIGIT_HI));
        return 8'($urandom_range(stok_pkg::CH_LETTER_LO, stok_pkg::CH_LETTER_HI));
    endfunction

    // one-byte operators first, then the bytes that may pair up
    function automatic logic [7:0] symbol_byte(int idx);
        case (idx)
            0:       return stok_pkg::CH_PLUS;
            1:       return stok_pkg::CH_MINUS;
            2:       return stok_pkg::CH_STAR;
            3:       return stok_pkg::CH_SLASH;
            4:       return stok_pkg::CH_SEMI;
            5:       return stok_pkg::CH_LPAREN;
            6:       return stok_pkg::CH_RPAREN;
            7:       return stok_pkg::CH_EQUAL;
            8:       return stok_pkg::CH_LESS;
            9:       return stok_pkg::CH_MORE;
            10:      return stok_pkg::CH_AMP;
            default: return stok_pkg::CH_BAR;
        endcase
    endfunction

    function automatic logic [7:0] space_byte();
        case ($urandom_range(0, 2))
            0:       return stok_pkg::CH_SPACE;
            1:       return stok_pkg::CH_TAB;
            default: return stok_pkg::CH_LF;
        endcase
    endfunction

    // append one random token, or one to four loose bytes, and maybe a separator to the text queue
    function automatic void queue_token();
        string w;
        int    pick;
        int    i;
        pick = $urandom_range(0, 99);
        if (pick < 22) begin
            // keyword, sometimes bent into a near miss
            w = sb.kw_text[$urandom_range(0, stok_pkg::KW_COUNT - 1)];
            for (i = 0; i < w.len(); i++) text_q.push_back(w[i]);
            case ($urandom_range(0, 3))
                1: text_q.push_back(word_char());
                2: void'(text_q.pop_back());
                3: begin
                    i = text_q.size() - 1 - int'($urandom_range(0, w.len() - 1));
                    text_q[i] = text_q[i] ^ 8'h20;
                end
                default: ;
            endcase
        end else if (pick < 36) begin
            text_q.push_back(8'($urandom_range(stok_pkg::CH_LETTER_LO,
                                               stok_pkg::CH_LETTER_HI)));
            repeat ($urandom_range(0, 7)) text_q.push_back(word_char());
        end else if (pick < 50) begin
            repeat ($urandom_range(1, 6))
                text_q.push_back(8'($urandom_range(stok_pkg::CH_DIGIT_LO,
                                                   stok_pkg::CH_DIGIT_HI)));
        end else if (pick < 68) begin
            text_q.push_back(symbol_byte($urandom_range(0, 6)));
        end else if (pick < 82) begin
            text_q.push_back(symbol_byte($urandom_range(7, 9)));
            if ($urandom_range(0, 1) == 1) text_q.push_back(stok_pkg::CH_EQUAL);
        end else if (pick < 93) begin
            text_q.push_back(symbol_byte($urandom_range(10, 11)));
            if ($urandom_range(0, 9) < 7) text_q.push_back(symbol_byte($urandom_range(10, 11)));
        end else begin
            // loose bytes from the accepted character set
            repeat ($urandom_range(1, 4)) begin
                case ($urandom_range(0, 3))
                    0:       text_q.push_back(word_char());
                    1:       text_q.push_back(8'($urandom_range(stok_pkg::CH_DIGIT_LO,
                                                                stok_pkg::CH_DIGIT_HI)));
                    2:       text_q.push_back(symbol_byte($urandom_range(0, 11)));
                    default: text_q.push_back(space_byte());
                endcase
            end
        end
        case ($urandom_range(0, 3))
            1, 2:    text_q.push_back(stok_pkg::CH_SPACE);
            3:       text_q.push_back(space_byte());
            default: ;
        endcase
    endfunction

    // offer one byte and hold it until the block takes it
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = idle_draw();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_source_byte <= b;
        i_final_byte  <= last;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        sb.scan_byte(b, last);
        src_pos = last ? 0 : src_pos + 1;
    endtask

    // next byte of the random text; sources are ended at random and well short of capacity
    task automatic feed_next(input bit allow_final);
        logic [7:0] b;
        logic       last;
        if (text_q.size() == 0) queue_token();
        b    = text_q.pop_front();
        last = allow_final && (src_pos >= 1000 || $urandom_range(0, 39) == 0);
        send_byte(b, last);
    endtask

    task automatic wait_for_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (sb.expected_tokens.size() != 0);
    endtask

    // result side: check each output transaction, stall at random
    initial begin : result_side
        int               hold;
        stok_pkg::t_token got;
        hold = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (o_valid === 1'b1 && i_stall === 1'b0) begin
                got.kind    = o_token_kind;
                got.kw_num  = o_keyword_number;
                got.start   = o_token_start;
                got.len     = o_token_length;
                got.status  = o_token_status;
                got.run_end = o_run_end;
                sb.check_token(got);
                hold = idle_draw();
            end
            if (hold_request) begin
                hold_request = 1'b0;
                hold         = LONG_HOLD;
            end
            if (hold > 0) begin
                i_stall <= 1'b1;
                hold--;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    initial begin : watchdog
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin : stimulus
        string      opening;
        int         i;
        int         n;
        int         long_runs;
        int         run_len;
        logic [7:0] b;
        sb        = new();
        long_runs = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // every token kind, lone and paired comparison and gate bytes, flush on the final byte
        opening = "do A<=9==>=<z=()-/*;&&||&|&+>";
        for (i = 0; i < opening.len(); i++) send_byte(opening[i], i == opening.len() - 1);

        // random token text with pressure events and runs at and past the length limit
        for (n = 0; n < RANDOM_BYTES; n++) begin
            if ($urandom_range(0, 79) == 0) calm = ~calm;
            if (n == 60) begin
                calm         = 1'b0;
                hold_request = 1'b1;
            end
            if (n == 120) wait_for_results();
            if (n % 60 == 30 && long_runs < LONG_RUNS) begin
                // a word at or just past the limit, then a number past it
                while (text_q.size() != 0) feed_next(1'b1);
                send_byte(stok_pkg::CH_SPACE, 1'b1);
                run_len = stok_pkg::MAX_TOKEN_CHARS + int'($urandom_range(0, 2)) + long_runs;
                for (i = 0; i < run_len; i++) begin
                    if (long_runs == 1)
                        text_q.push_back(8'($urandom_range(stok_pkg::CH_DIGIT_LO,
                                                           stok_pkg::CH_DIGIT_HI)));
                    else if (i == 0)
                        text_q.push_back(8'($urandom_range(stok_pkg::CH_LETTER_LO,
                                                           stok_pkg::CH_LETTER_HI)));
                    else
                        text_q.push_back(word_char());
                end
                text_q.push_back(stok_pkg::CH_SPACE);
                while (text_q.size() != 0) feed_next(1'b0);
                long_runs++;
            end
            feed_next(1'b1);
        end
        while (text_q.size() != 0) feed_next(1'b1);

        // end on a halting error: unknown symbol after a pending word
        send_byte("q", 1'b0);
        send_byte("7", 1'b0);
        case ($urandom_range(0, 3))
            0:       b = 8'h00;
            1:       b = 8'hFF;
            2:       b = 8'($urandom_range(125, 255));
            default: b = 8'($urandom_range(1, 8));
        endcase
        send_byte(b, 1'b0);
        // halted: these bytes are taken and give nothing
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte("x", 1'b1);

        wait_for_results();
        calm = 1'b1;
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.expected_tokens.size() == 0) $display("RESULT: OK");
        else $display("RESULT: ERROR");
        $finish;
    end

endmodule
